// ===== rtl/fcmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcmc_pkg: shared types and constants
// Opcodes and class codes of the compare / min / max / classify unit.
// ----------------------------------------------------------------------------
package fcmc_pkg;

  typedef enum logic [2:0] {
    OP_CLASSIFY = 3'd0,
    OP_MIN      = 3'd1,
    OP_MAX      = 3'd2,
    OP_CLAMP    = 3'd3,
    OP_LESS     = 3'd4,
    OP_GREATER  = 3'd5,
    OP_ULP_EQ   = 3'd6,
    OP_ABS      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    CLS_NAN       = 3'd0,
    CLS_INF       = 3'd1,
    CLS_ZERO      = 3'd2,
    CLS_SUBNORMAL = 3'd3,
    CLS_NORMAL    = 3'd4
  } cls_e;

  localparam int unsigned UlpW = 10;
  localparam logic [UlpW-1:0] UlpReset = 10'd4;
  localparam logic [63:0] Word32Mask = 64'h0000_0000_FFFF_FFFF;

endpackage

// ===== rtl/fp_compare_minmax_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp_compare_minmax_classify: IEEE compare, min/max/clamp, classify, abs
// Single-pass bit-field unit over binary32 or binary64 operands.
// ----------------------------------------------------------------------------
// One word in, one word out. Each word passes an input register, one level of
// key compares and muxes, then a result register; a new word is taken every
// cycle, bounded only by downstream stall.
module fp_compare_minmax_classify import fcmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [UlpW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       opcode_i,
  input  logic             is_double_i,
  input  logic [63:0]      operand_a_i,
  input  logic [63:0]      operand_b_i,
  input  logic [63:0]      operand_c_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [63:0]      result_value_o,
  output logic             result_flag_o,
  output logic [2:0]       class_code_o
);

  logic [UlpW-1:0] ulp_q;
  logic            s1_valid_q;
  op_e             op_q;
  logic            dbl_q;
  logic [63:0]     a_q, b_q, c_q;
  logic            s1_adv, s2_load;

  assign s2_load    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_adv     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ulp_q <= UlpReset;
    end else if (cfg_we_i) begin
      ulp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b1;
    end else if (s2_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      op_q  <= op_e'(opcode_i);
      dbl_q <= is_double_i;
      a_q   <= is_double_i ? operand_a_i : (operand_a_i & Word32Mask);
      b_q   <= is_double_i ? operand_b_i : (operand_b_i & Word32Mask);
      c_q   <= is_double_i ? operand_c_i : (operand_c_i & Word32Mask);
    end
  end

  function automatic logic [63:0] sign_m(input logic dbl);
    return dbl ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
  endfunction

  function automatic logic [63:0] exp_m(input logic dbl);
    return dbl ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
  endfunction

  function automatic logic [63:0] man_m(input logic dbl);
    return dbl ? 64'h000F_FFFF_FFFF_FFFF : 64'h0000_0000_007F_FFFF;
  endfunction

  function automatic logic f_nan(input logic [63:0] x, input logic dbl);
    return ((x & exp_m(dbl)) == exp_m(dbl)) && ((x & man_m(dbl)) != 64'd0);
  endfunction

  function automatic logic f_zero(input logic [63:0] x, input logic dbl);
    return (x & ~sign_m(dbl)) == 64'd0;
  endfunction

  function automatic logic [63:0] f_key(input logic [63:0] x, input logic dbl);
    logic [63:0] mag;
    mag = x & ~sign_m(dbl);
    return ((x & sign_m(dbl)) != 64'd0) ? (64'h8000_0000_0000_0000 - mag)
                                        : (64'h8000_0000_0000_0000 + mag);
  endfunction

  function automatic logic [63:0] f_min(input logic [63:0] x, input logic [63:0] y,
                                        input logic dbl);
    logic [63:0] r;
    if (f_nan(x, dbl)) r = y;
    else if (f_nan(y, dbl)) r = x;
    else if (f_zero(x, dbl) && f_zero(y, dbl)) r = ((x & sign_m(dbl)) != 0) ? x : y;
    else r = (f_key(x, dbl) < f_key(y, dbl)) ? x : y;
    return r;
  endfunction

  function automatic logic [63:0] f_max(input logic [63:0] x, input logic [63:0] y,
                                        input logic dbl);
    logic [63:0] r;
    if (f_nan(x, dbl)) r = y;
    else if (f_nan(y, dbl)) r = x;
    else if (f_zero(x, dbl) && f_zero(y, dbl)) r = ((x & sign_m(dbl)) != 0) ? y : x;
    else r = (f_key(x, dbl) > f_key(y, dbl)) ? x : y;
    return r;
  endfunction

  logic [63:0] ka, kb, key_dist, mx, val_d;
  logic        any_nan, flag_d;
  logic [2:0]  cls_d;
  logic [63:0] ea, ma;

  always_comb begin
    ka       = f_key(a_q, dbl_q);
    kb       = f_key(b_q, dbl_q);
    key_dist = (ka > kb) ? (ka - kb) : (kb - ka);
    any_nan  = f_nan(a_q, dbl_q) || f_nan(b_q, dbl_q);
    mx       = f_max(a_q, b_q, dbl_q);
    ea       = a_q & exp_m(dbl_q);
    ma       = a_q & man_m(dbl_q);
    val_d    = 64'd0;
    flag_d   = 1'b0;
    cls_d    = CLS_NAN;
    case (op_q)
      OP_CLASSIFY: begin
        if (ea == exp_m(dbl_q)) cls_d = (ma != 64'd0) ? CLS_NAN : CLS_INF;
        else if (ea == 64'd0) cls_d = (ma == 64'd0) ? CLS_ZERO : CLS_SUBNORMAL;
        else cls_d = CLS_NORMAL;
      end
      OP_MIN:     val_d = f_min(a_q, b_q, dbl_q);
      OP_MAX:     val_d = mx;
      OP_CLAMP:   val_d = f_min(mx, c_q, dbl_q);
      OP_LESS:    flag_d = !any_nan && (ka < kb);
      OP_GREATER: flag_d = !any_nan && (ka > kb);
      OP_ULP_EQ:  flag_d = !any_nan && (key_dist <= {54'd0, ulp_q});
      OP_ABS:     val_d = a_q & ~sign_m(dbl_q);
      default:    val_d = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s2_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      result_value_o <= val_d;
      result_flag_o  <= flag_d;
      class_code_o   <= cls_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o))
    else $error("result dropped under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("stall without full pipe");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !in_stall_o |=> out_valid_o)
    else $error("word lost between stages");

endmodule

// ===== dv/fp_compare_minmax_classify_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp_compare_minmax_classify_test: self-checking bench for the fp compare unit
// Drives directed and random words in both formats over every opcode, predicts
// each result from the raw bits, and checks it field by field against the
// output. Both sides idle at random; the ulp limit is swept between phases.
// ----------------------------------------------------------------------------
module fp_compare_minmax_classify_test;
  import fcmc_pkg::*;

  typedef struct {
    op_e         op;
    logic        dbl;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } fp_word_t;

  typedef struct {
    logic [63:0] value;
    logic        flag;
    logic [2:0]  cls;
  } fp_result_t;

  localparam logic [63:0] Sign64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Exp64  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] Man64  = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] Sign32 = 64'h8000_0000;
  localparam logic [63:0] Exp32  = 64'h7F80_0000;
  localparam logic [63:0] Man32  = 64'h007F_FFFF;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [UlpW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  logic is_double_i = 1'b0;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic [63:0] operand_c_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [63:0] result_value_o;
  logic result_flag_o;
  logic [2:0] class_code_o;

  fp_compare_minmax_classify dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .opcode_i, .is_double_i, .operand_a_i, .operand_b_i, .operand_c_i,
    .out_valid_o, .out_stall_i, .result_value_o, .result_flag_o, .class_code_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  fp_word_t   pending_words[$];
  fp_result_t expected_results[$];
  logic [UlpW-1:0] ulp_limit = UlpReset;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_gap = 0;
  bit hold_sender = 1'b0;
  bit quiet = 1'b0;
  bit timed_out = 1'b0;

  function automatic logic [63:0] sgn_m(logic d);
    return d ? Sign64 : Sign32;
  endfunction

  function automatic logic is_nan(logic [63:0] x, logic d);
    logic [63:0] e;
    logic [63:0] m;
    e = d ? Exp64 : Exp32;
    m = d ? Man64 : Man32;
    return ((x & e) == e) && ((x & m) != 0);
  endfunction

  function automatic logic is_zero(logic [63:0] x, logic d);
    return (x & ~sgn_m(d)) == 0;
  endfunction

  function automatic logic [63:0] order_key(logic [63:0] x, logic d);
    logic [63:0] mag;
    mag = x & ~sgn_m(d);
    return ((x & sgn_m(d)) != 0) ? Sign64 - mag : Sign64 + mag;
  endfunction

  function automatic logic [63:0] pick_min(logic [63:0] a, logic [63:0] b, logic d);
    if (is_nan(a, d)) return b;
    if (is_nan(b, d)) return a;
    if (is_zero(a, d) && is_zero(b, d)) return ((a & sgn_m(d)) != 0) ? a : b;
    return (order_key(a, d) < order_key(b, d)) ? a : b;
  endfunction

  function automatic logic [63:0] pick_max(logic [63:0] a, logic [63:0] b, logic d);
    if (is_nan(a, d)) return b;
    if (is_nan(b, d)) return a;
    if (is_zero(a, d) && is_zero(b, d)) return ((a & sgn_m(d)) != 0) ? b : a;
    return (order_key(a, d) > order_key(b, d)) ? a : b;
  endfunction

  function automatic fp_result_t compute_result(fp_word_t w);
    fp_result_t r;
    logic [63:0] keep;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] key_dist;
    logic [63:0] e;
    logic [63:0] m;
    logic nan_in;
    keep = w.dbl ? '1 : Word32Mask;
    a = w.a & keep;
    b = w.b & keep;
    c = w.c & keep;
    ka = order_key(a, w.dbl);
    kb = order_key(b, w.dbl);
    nan_in = is_nan(a, w.dbl) || is_nan(b, w.dbl);
    key_dist = (ka > kb) ? ka - kb : kb - ka;
    e = a & (w.dbl ? Exp64 : Exp32);
    m = a & (w.dbl ? Man64 : Man32);
    r.value = '0;
    r.flag = 1'b0;
    r.cls = '0;
    case (w.op)
      OP_CLASSIFY: begin
        if (e == (w.dbl ? Exp64 : Exp32)) r.cls = (m != 0) ? CLS_NAN : CLS_INF;
        else if (e == 0) r.cls = (m == 0) ? CLS_ZERO : CLS_SUBNORMAL;
        else r.cls = CLS_NORMAL;
      end
      OP_MIN: r.value = pick_min(a, b, w.dbl);
      OP_MAX: r.value = pick_max(a, b, w.dbl);
      OP_CLAMP: r.value = pick_min(pick_max(a, b, w.dbl), c, w.dbl);
      OP_LESS: r.flag = !nan_in && (ka < kb);
      OP_GREATER: r.flag = !nan_in && (ka > kb);
      OP_ULP_EQ: r.flag = !nan_in && (key_dist <= {54'd0, ulp_limit});
      default: r.value = a & ~sgn_m(w.dbl);
    endcase
    r.value &= keep;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(compute_result(pending_words.pop_front()));
        words_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!hold_sender && pending_words.size() > 0) begin
          in_valid_i <= 1'b1;
          opcode_i <= pending_words[0].op;
          is_double_i <= pending_words[0].dbl;
          operand_a_i <= pending_words[0].a;
          operand_b_i <= pending_words[0].b;
          operand_c_i <= pending_words[0].c;
          if (!quiet && $urandom_range(9) == 0)
            send_gap = ($urandom_range(7) == 0) ? $urandom_range(40, 10)
                                                : $urandom_range(3, 1);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    fp_result_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && !in_stall_o) idle_cycles = 0;
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        results_checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", result_value_o);
        end else begin
          want = expected_results.pop_front();
          if (result_value_o !== want.value || result_flag_o !== want.flag ||
              class_code_o !== want.cls) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value %h/%h flag %b/%b class %0d/%0d (exp/act)",
                       want.value, result_value_o, want.flag, result_flag_o,
                       want.cls, class_code_o);
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet && $urandom_range(9) == 0)
          stall_gap = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("fp_compare_minmax_classify test failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // special-leaning operand
  function automatic logic [63:0] rand_operand(logic d);
    logic [63:0] x;
    x = rand64();
    case ($urandom_range(9))
      0: x = d ? (x & Sign64) : ((x & Sign32) | (x & ~Word32Mask));
      1: x = d ? ((x & Sign64) | Exp64) : (x & ~(Exp32 | Man32)) | Exp32;
      2: x = d ? (x | Exp64) : (x | Exp32);
      3: x = d ? (x & ~Exp64) : (x & ~Exp32);
      default: ;
    endcase
    return x;
  endfunction

  function automatic logic [63:0] near(logic [63:0] x, logic d);
    logic [63:0] y;
    y = x + 64'($urandom_range(12)) - 64'd6;
    return d ? y : {x[63:32], y[31:0]};
  endfunction

  task automatic add_word(op_e op, logic d, logic [63:0] a, logic [63:0] b,
                          logic [63:0] c);
    fp_word_t w;
    w.op = op;
    w.dbl = d;
    w.a = a;
    w.b = b;
    w.c = c;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic set_ulp_limit(logic [UlpW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ulp_limit = v;
  endtask

  task automatic add_random(int unsigned n);
    logic d;
    logic [63:0] a;
    logic [63:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      d = 1'($urandom_range(1));
      a = rand_operand(d);
      b = ($urandom_range(2) == 0) ? near(a, d) : rand_operand(d);
      add_word(op_e'($urandom_range(7)), d, a, b, rand_operand(d));
    end
  endtask

  initial begin
    logic [UlpW-1:0] limits[4];
    limits = '{10'd0, 10'd1023, 10'd1, 10'd37};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes and special cases
    add_word(OP_CLASSIFY, 1'b1, 64'h7FF8_0000_0000_0000, 64'h0, 64'h0);
    add_word(OP_CLASSIFY, 1'b1, 64'hFFF0_0000_0000_0000, 64'h0, 64'h0);
    add_word(OP_CLASSIFY, 1'b1, 64'h8000_0000_0000_0000, 64'h0, 64'h0);
    add_word(OP_CLASSIFY, 1'b1, 64'h0000_0000_0000_0001, 64'h0, 64'h0);
    add_word(OP_CLASSIFY, 1'b0, 64'hFFFF_FFFF_3F80_0000, 64'h0, 64'h0);
    add_word(OP_CLASSIFY, 1'b0, 64'h0000_0000_7FC0_0001, 64'h0, 64'h0);
    add_word(OP_MIN, 1'b1, 64'h8000_0000_0000_0000, 64'h0, 64'h0);
    add_word(OP_MAX, 1'b1, 64'h8000_0000_0000_0000, 64'h0, 64'h0);
    add_word(OP_MIN, 1'b0, 64'h0, 64'h8000_0000, 64'h0);
    add_word(OP_MAX, 1'b0, 64'hDEAD_0000_8000_0000, 64'h0, 64'h0);
    add_word(OP_MIN, 1'b0, 64'h7FC0_0000, 64'h7F80_0001, 64'h0);
    add_word(OP_MAX, 1'b1, 64'h7FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000, 64'h0);
    add_word(OP_MIN, 1'b1, 64'h3FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    add_word(OP_CLAMP, 1'b1, 64'h4010_0000_0000_0000, 64'h0, 64'h3FF0_0000_0000_0000);
    add_word(OP_CLAMP, 1'b0, 64'h7FC0_0000, 64'h7FC0_0001, 64'h3F80_0000);
    add_word(OP_LESS, 1'b1, 64'h8000_0000_0000_0000, 64'h0, 64'h0);
    add_word(OP_LESS, 1'b1, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'h0);
    add_word(OP_GREATER, 1'b0, 64'h7F80_0000, 64'h7FC0_0000, 64'h0);
    add_word(OP_GREATER, 1'b0, 64'h3F80_0001, 64'hBF80_0000, 64'h0);
    add_word(OP_ULP_EQ, 1'b1, 64'h0000_0000_0000_0002, 64'h8000_0000_0000_0002, 64'h0);
    add_word(OP_ULP_EQ, 1'b0, 64'h3F80_0000, 64'h3F80_0005, 64'h0);
    add_word(OP_ULP_EQ, 1'b0, 64'h7FC0_0000, 64'h7FC0_0000, 64'h0);
    add_word(OP_ABS, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0);
    add_word(OP_ABS, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0);
    drain();
    // random phases over several ulp limits, one pass without idling
    foreach (limits[i]) begin
      set_ulp_limit(limits[i]);
      quiet = (i == 2);
      add_random(220);
      if (i == 1) begin
        while (pending_words.size() > 150) @(posedge clk_i);
        hold_sender = 1'b1;
        while (expected_results.size() > 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      drain();
    end
    $display("checked %0d results from %0d words over all opcodes, both formats",
             results_checked, words_sent);
    $display("ulp limits swept: 4, 0, 1023, 1, 37");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("fp_compare_minmax_classify test passed");
    end else begin
      $display("fp_compare_minmax_classify test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fcmc_pkg.sv
rtl/fp_compare_minmax_classify.sv
dv/fp_compare_minmax_classify_test.sv
